// ----- src/cpg_pkg.sv -----
// cpg_pkg: shared constants for the circle point generator.
// Command codes, octant codes, decision-variable constants, queue depth.
// No dependencies.
package cpg_pkg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam int OCT_W = 3;
    localparam logic [OCT_W-1:0] OCT_FIRST = 3'd0;
    localparam logic [OCT_W-1:0] OCT_LAST  = 3'd7;

    // Bresenham decision-variable constants
    localparam int DEC_INIT     = 3;   // d0 = 3 - 2r
    localparam int DEC_STEP_MUL = 4;   // scale of the coordinate terms
    localparam int DEC_ADD_DIAG = 10;  // d >= 0: d + 4(x-y) + 10
    localparam int DEC_ADD_AXIS = 6;   // d <  0: d + 4x + 6

    // front-to-back job queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

endpackage

// ----- src/cpg_if.sv -----
// cpg_if: valid/ready channels of the circle point generator.
// cpg_req_if carries commands in, cpg_res_if carries results out.
// Depends on nothing; widths follow COORD_BITS.
interface cpg_req_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-2:0] radius;

    modport source (output valid, output cmd, output center_x, output center_y,
                    output radius, input ready);
    modport sink   (input valid, input cmd, input center_x, input center_y,
                    input radius, output ready);
endinterface

interface cpg_res_if #(
    parameter int COORD_BITS = 10
);
    logic                        valid;
    logic                        ready;
    logic signed [COORD_BITS+1:0] point_x;
    logic signed [COORD_BITS+1:0] point_y;
    logic [2:0]                  octant;
    logic                        last;
    logic                        done_res;

    modport source (output valid, output point_x, output point_y, output octant,
                    output last, output done_res, input ready);
    modport sink   (input valid, input point_x, input point_y, input octant,
                    input last, input done_res, output ready);
endinterface

// ----- src/circle_point_generator.sv -----
// circle_point_generator: midpoint circle rasterizer, start/step command in, points out.
// With the queue empty, a step's job passes the queue, then the output register, to the result port.
// Throughput: eight results per step, one per cycle unless results stall; done gives one, start none.
// Sustained rate is set by the single result port.
// Reset (rst_n, async, low): circle idle, queue empty, no result pending.
module circle_point_generator #(
    parameter int COORD_BITS = 10
) (
    input  logic      clk,
    input  logic      rst_n,
    cpg_req_if.sink   req,
    cpg_res_if.source res
);
    // job word: done flag, center x/y, current x/y
    localparam int JOB_W = 1 + 4 * COORD_BITS;

    logic             q_full;
    logic             push;
    logic [JOB_W-1:0] push_data;
    logic             pop;
    logic             head_valid;
    logic [JOB_W-1:0] head_data;

    // Front: owns the Bresenham state. Every accepted step decides its job
    // (eight points or done) from the state before the move, then advances.
    // It takes a new command in any cycle the queue has room.
    cpg_front #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Two-entry queue decouples command transfers from result backpressure.
    cpg_queue #(
        .JOB_W (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // Back: walks the eight reflections of the head job (or one done result), one per
    // cycle unless the result port stalls, into a registered output stage; pops the job with the last one.
    cpg_back #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .res        (res)
    );

    // done results carry no point and always close their command
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.done_res |-> res.last && res.octant == cpg_pkg::OCT_FIRST)
        else $error("done result not marked last");
endmodule

// ----- src/cpg_front.sv -----
// cpg_front: accepts commands and runs the circle state (center, x, y, decision).
// Each step pushes one job (eight points or done) into the queue.
// Depends on cpg_pkg, cpg_req_if.
module cpg_front #(
    parameter int COORD_BITS = 10,
    parameter int JOB_W      = 1 + 4 * COORD_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    cpg_req_if.sink          req,
    input  logic             q_full,
    output logic             push,
    output logic [JOB_W-1:0] push_data
);
    localparam int CB    = COORD_BITS;
    localparam int DEC_W = COORD_BITS + 3;

    typedef struct packed {
        logic          done;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } job_t;

    logic [CB-1:0]    cx_reg, cx_next;
    logic [CB-1:0]    cy_reg, cy_next;
    logic [CB-1:0]    x_reg, x_next;
    logic [CB-1:0]    y_reg, y_next;
    logic [DEC_W-1:0] d_reg, d_next;
    logic             running_reg, running_next;

    logic             accept;
    logic             step_ok;
    logic [DEC_W-1:0] d_diag, d_axis, d_init;
    job_t             job;

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;
    assign step_ok   = running_reg && (y_reg >= x_reg);

    // all decision arithmetic wraps in DEC_W bits
    assign d_init = DEC_W'(cpg_pkg::DEC_INIT) - (DEC_W'(req.radius) << 1);
    assign d_diag = d_reg + DEC_W'(cpg_pkg::DEC_STEP_MUL) * (DEC_W'(x_reg) - DEC_W'(y_reg))
                    + DEC_W'(cpg_pkg::DEC_ADD_DIAG);
    assign d_axis = d_reg + DEC_W'(cpg_pkg::DEC_STEP_MUL) * DEC_W'(x_reg)
                    + DEC_W'(cpg_pkg::DEC_ADD_AXIS);

    always_comb
    begin
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        d_next       = d_reg;
        running_next = running_reg;
        if (accept)
        begin
            if (req.cmd == cpg_pkg::CMD_START)
            begin
                cx_next      = req.center_x;
                cy_next      = req.center_y;
                x_next       = '0;
                y_next       = CB'(req.radius);
                d_next       = d_init;
                running_next = 1'b1;
            end
            else if (step_ok)
            begin
                if (!d_reg[DEC_W-1])
                begin
                    d_next = d_diag;
                    if (y_reg != '0)
                    begin
                        y_next = y_reg - 1'b1;
                    end
                end
                else
                begin
                    d_next = d_axis;
                end
                x_next = x_reg + 1'b1;
            end
            else
            begin
                running_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        job.done = !step_ok;
        job.cx   = cx_reg;
        job.cy   = cy_reg;
        job.x    = x_reg;
        job.y    = y_reg;
    end

    assign push      = accept && (req.cmd == cpg_pkg::CMD_STEP);
    assign push_data = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg      <= '0;
            cy_reg      <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            d_reg       <= '0;
            running_reg <= 1'b0;
        end
        else
        begin
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            d_reg       <= d_next;
            running_reg <= running_next;
        end
    end

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.cmd == cpg_pkg::CMD_START |=> running_reg && x_reg == '0)
        else $error("start did not arm the circle");
endmodule

// ----- src/cpg_queue.sv -----
// cpg_queue: short FIFO of jobs between front and back.
// Depends on cpg_pkg.
module cpg_queue #(
    parameter int JOB_W = 41
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [JOB_W-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output logic [JOB_W-1:0] head_data
);
    logic [JOB_W-1:0]          slot_reg [cpg_pkg::QUEUE_DEPTH];
    logic [cpg_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cpg_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == cpg_pkg::QCNT_W'(cpg_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("job popped from empty queue");
endmodule

// ----- src/cpg_back.sv -----
// cpg_back: expands the head job into eight reflected points or one done result.
// One result per cycle into the output register while it is empty or being read.
// Depends on cpg_pkg, cpg_res_if.
module cpg_back #(
    parameter int COORD_BITS = 10,
    parameter int JOB_W      = 1 + 4 * COORD_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  logic [JOB_W-1:0] head_data,
    output logic             pop,
    cpg_res_if.source        res
);
    localparam int CB    = COORD_BITS;
    localparam int OUT_W = COORD_BITS + 2;

    typedef struct packed {
        logic          done;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } job_t;

    job_t                      job;
    logic [cpg_pkg::OCT_W-1:0] oct_reg, oct_next;
    logic                      fire;
    logic [OUT_W-1:0]          a_ext, b_ext, cx_ext, cy_ext;
    logic [OUT_W-1:0]          px, py;

    logic                      valid_reg;
    logic signed [OUT_W-1:0]   px_reg, py_reg;
    logic [cpg_pkg::OCT_W-1:0] res_oct_reg;
    logic                      last_reg, done_reg;

    assign job  = head_data;
    assign fire = head_valid && (!valid_reg || res.ready);
    assign pop  = fire && (job.done || oct_reg == cpg_pkg::OCT_LAST);

    // octant bit 2 swaps x and y, bit 0 negates the x offset, bit 1 the y offset
    assign a_ext  = OUT_W'(oct_reg[2] ? job.y : job.x);
    assign b_ext  = OUT_W'(oct_reg[2] ? job.x : job.y);
    assign cx_ext = OUT_W'(job.cx);
    assign cy_ext = OUT_W'(job.cy);
    assign px     = oct_reg[0] ? (cx_ext - a_ext) : (cx_ext + a_ext);
    assign py     = oct_reg[1] ? (cy_ext - b_ext) : (cy_ext + b_ext);

    always_comb
    begin
        oct_next = oct_reg;
        if (pop)
        begin
            oct_next = cpg_pkg::OCT_FIRST;
        end
        else if (fire)
        begin
            oct_next = oct_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (job.done)
            begin
                px_reg      <= '0;
                py_reg      <= '0;
                res_oct_reg <= cpg_pkg::OCT_FIRST;
                last_reg    <= 1'b1;
                done_reg    <= 1'b1;
            end
            else
            begin
                px_reg      <= px;
                py_reg      <= py;
                res_oct_reg <= oct_reg;
                last_reg    <= (oct_reg == cpg_pkg::OCT_LAST);
                done_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg   <= cpg_pkg::OCT_FIRST;
            valid_reg <= 1'b0;
        end
        else
        begin
            oct_reg <= oct_next;
            if (fire)
            begin
                valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid    = valid_reg;
    assign res.point_x  = px_reg;
    assign res.point_y  = py_reg;
    assign res.octant   = res_oct_reg;
    assign res.last     = last_reg;
    assign res.done_res = done_reg;

    a_mid_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        oct_reg != cpg_pkg::OCT_FIRST |-> head_valid && !job.done)
        else $error("job left the queue part way through its points");
endmodule

// ----- tb/tb_circle_point_generator.sv -----
// tb_circle_point_generator: self-checking testbench for the midpoint circle rasterizer.
// Drives start/step commands with random gaps, predicts every point and done transfer.
// Depends on cpg_pkg, cpg_req_if, cpg_res_if and circle_point_generator.
module tb_circle_point_generator;

    localparam int COORD_BITS    = 10;
    localparam int PT_BITS       = COORD_BITS + 2;
    localparam int DEC_BITS      = COORD_BITS + 3;
    localparam int ITEM_TARGET   = 480;   // least number of commands to send in total
    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up
    localparam int LONG_HOLD     = 200;   // receiver hold-off for the backpressure test
    localparam int SETTLE_CYCLES = 20;    // quiet cycles after the last result

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-2:0] radius_t;

    // one expected transfer on the result channel
    typedef struct packed {
        logic signed [PT_BITS-1:0]     point_x;
        logic signed [PT_BITS-1:0]     point_y;
        logic [cpg_pkg::OCT_W-1:0]     octant;
        logic                          last;
        logic                          done_res;
    } pixel_t;

    logic clk;
    logic rst_n;

    cpg_req_if #(.COORD_BITS(COORD_BITS)) req ();
    cpg_res_if #(.COORD_BITS(COORD_BITS)) res ();

    circle_point_generator #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .res  (res)
    );

    // expected points, oldest first
    pixel_t pixel_q[$];

    // shadow of the rasterizer state
    coord_t                     ctr_x;
    coord_t                     ctr_y;
    coord_t                     arc_x;
    coord_t                     arc_y;
    logic signed [DEC_BITS-1:0] dec_var;
    logic                       circle_on;

    int   cmds_sent;
    int   mismatches;
    int   idle_cycles;
    int   burst_left;
    logic back_to_back;  // sender drops its gaps while set
    logic hold_req;      // asks the receiver for one long hold-off

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic pixel_t make_pixel(input int px, input int py,
                                          input logic [cpg_pkg::OCT_W-1:0] oct,
                                          input logic is_last, input logic is_done);
        pixel_t p;
        p.point_x  = PT_BITS'(px);
        p.point_y  = PT_BITS'(py);
        p.octant   = oct;
        p.last     = is_last;
        p.done_res = is_done;
        return p;
    endfunction

    // Advance the shadow state by one accepted command and queue what it produces.
    task automatic rasterize_cmd(input logic op, input coord_t cx, input coord_t cy,
                                 input radius_t r);
        int x;
        int y;
        int d;
        int a;
        int b;
        int k;
        if (op == cpg_pkg::CMD_START)
        begin
            // start emits nothing; it only loads the circle
            ctr_x     = cx;
            ctr_y     = cy;
            arc_x     = '0;
            arc_y     = coord_t'(r);
            dec_var   = DEC_BITS'(cpg_pkg::DEC_INIT - 2 * int'(r));
            circle_on = 1'b1;
        end
        else if (!circle_on || arc_y < arc_x)
        begin
            // finished circle, or a step with nothing running: one done transfer
            circle_on = 1'b0;
            pixel_q.push_back(make_pixel(0, 0, cpg_pkg::OCT_FIRST, 1'b1, 1'b1));
        end
        else
        begin
            x = int'(arc_x);
            y = int'(arc_y);
            d = int'(dec_var);
            // octants 0-3 reflect (x, y); 4-7 reflect the swapped pair.
            // bit 0 negates the first offset, bit 1 the second.
            for (k = 0; k < 8; k++)
            begin
                a = (k < 4) ? x : y;
                b = (k < 4) ? y : x;
                pixel_q.push_back(make_pixel((k % 2 != 0) ? int'(ctr_x) - a : int'(ctr_x) + a,
                                             ((k / 2) % 2 != 0) ? int'(ctr_y) - b
                                                                : int'(ctr_y) + b,
                                             cpg_pkg::OCT_W'(k),
                                             k == int'(cpg_pkg::OCT_LAST), 1'b0));
            end
            // decision update uses x, y from before the move; y holds at zero
            if (d >= 0)
            begin
                dec_var = DEC_BITS'(d + cpg_pkg::DEC_STEP_MUL * (x - y) + cpg_pkg::DEC_ADD_DIAG);
                if (arc_y != '0)
                    arc_y = arc_y - 1'b1;
            end
            else
                dec_var = DEC_BITS'(d + cpg_pkg::DEC_STEP_MUL * x + cpg_pkg::DEC_ADD_AXIS);
            arc_x = arc_x + 1'b1;
        end
    endtask

    // Send one command. The sender runs in bursts; between bursts it may idle.
    // Valid stays high across back-to-back transfers, so it is only written once per edge.
    task automatic send_cmd(input logic op, input coord_t cx, input coord_t cy,
                            input radius_t r);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (!back_to_back && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 9);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid    <= 1'b1;
        req.cmd      <= op;
        req.center_x <= cx;
        req.center_y <= cy;
        req.radius   <= r;
        do
            @(posedge clk);
        while (!req.ready);
        // transfer happened at this edge; any results pass the job queue and the output register first
        cmds_sent++;
        rasterize_cmd(op, cx, cy, r);
    endtask

    // steps ignore the payload, so it is randomized to toggle every bit
    task automatic send_step();
        send_cmd(cpg_pkg::CMD_STEP, coord_t'($urandom), coord_t'($urandom),
                 radius_t'($urandom));
    endtask

    task automatic test_step_without_circle();
        send_cmd(cpg_pkg::CMD_STEP, '1, '1, '1);
    endtask

    // zero radius: center eight times, then done; a further step is done again
    task automatic test_zero_radius();
        send_cmd(cpg_pkg::CMD_START, '1, '0, '0);
        send_step();
        send_step();
        send_step();
    endtask

    // extreme centers with the largest radius, each abandoned by the next start, then a
    // radius-one circle run to the end; covers coordinates below zero and past 1023
    task automatic test_coordinate_extremes();
        send_cmd(cpg_pkg::CMD_START, '1, '1, '1);
        repeat (3) send_step();
        send_cmd(cpg_pkg::CMD_START, '0, '0, '1);
        repeat (3) send_step();
        send_cmd(cpg_pkg::CMD_START, coord_t'(512), coord_t'(341), radius_t'(1));
        do
            send_step();
        while (circle_on);
    endtask

    task automatic test_complete_circle();
        send_cmd(cpg_pkg::CMD_START, coord_t'(100), coord_t'(900), radius_t'(7));
        do
            send_step();
        while (circle_on);
    endtask

    // receiver holds off while steps keep coming, so the job queue fills
    // and the command channel has to stall
    task automatic test_output_backpressure();
        back_to_back = 1'b1;
        burst_left   = 0;
        hold_req     = 1'b1;
        send_cmd(cpg_pkg::CMD_START, coord_t'(600), coord_t'(200), radius_t'(300));
        repeat (12) send_step();
        back_to_back = 1'b0;
    endtask

    // mostly complete small circles with random content; the rest is
    // stray steps and large circles cut short by a new start
    task automatic test_random_traffic();
        int kind;
        int n;
        while (cmds_sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                send_step();
            else if (kind == 1)
            begin
                send_cmd(cpg_pkg::CMD_START, coord_t'($urandom), coord_t'($urandom),
                         radius_t'($urandom));
                n = $urandom_range(0, 10);
                repeat (n) send_step();
            end
            else
            begin
                send_cmd(cpg_pkg::CMD_START, coord_t'($urandom), coord_t'($urandom),
                         radius_t'($urandom_range(0, 24)));
                do
                    send_step();
                while (circle_on);
                if ($urandom_range(0, 2) == 0)
                    send_step();
            end
        end
    endtask

    // Result sink: ready changes at the falling edge. The stall pattern switches
    // among always-ready, mostly-ready, mostly-stalled and a periodic mode.
    initial
    begin : result_sink
        int mode;
        int mode_left;
        int phase;
        res.ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       res.ready <= 1'b1;
                    1:       res.ready <= ($urandom_range(0, 3) != 0);
                    2:       res.ready <= ($urandom_range(0, 3) == 0);
                    default: res.ready <= (phase % 7 >= 2);
                endcase
            end
        end
    end

    // Result checker and stall watchdog, both sampled at the rising edge.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pixel_q.size() == 0)
            begin
                $error("unexpected transfer: point_x %0d point_y %0d octant %0d done_res %0b",
                       res.point_x, res.point_y, res.octant, res.done_res);
                mismatches++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (res.point_x !== want.point_x)
                begin
                    $error("point_x: expected %0d, got %0d", want.point_x, res.point_x);
                    mismatches++;
                end
                if (res.point_y !== want.point_y)
                begin
                    $error("point_y: expected %0d, got %0d", want.point_y, res.point_y);
                    mismatches++;
                end
                if (res.octant !== want.octant)
                begin
                    $error("octant: expected %0d, got %0d", want.octant, res.octant);
                    mismatches++;
                end
                if (res.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, res.last);
                    mismatches++;
                end
                if (res.done_res !== want.done_res)
                begin
                    $error("done_res: expected %0b, got %0b", want.done_res, res.done_res);
                    mismatches++;
                end
            end
        end
        if (!rst_n || (req.valid && req.ready) || (res.valid && res.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   STALL_LIMIT, pixel_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        // every input known from time zero
        req.valid    = 1'b0;
        req.cmd      = cpg_pkg::CMD_START;
        req.center_x = '0;
        req.center_y = '0;
        req.radius   = '0;
        rst_n        = 1'b0;
        back_to_back = 1'b0;
        hold_req     = 1'b0;
        burst_left   = 0;
        cmds_sent    = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        ctr_x        = '0;
        ctr_y        = '0;
        arc_x        = '0;
        arc_y        = '0;
        dec_var      = '0;
        circle_on    = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_step_without_circle();
        test_zero_radius();
        test_coordinate_extremes();
        test_complete_circle();
        test_output_backpressure();
        test_random_traffic();

        @(negedge clk);
        req.valid <= 1'b0;
        // the watchdog ends the run if results stop arriving
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
